FILE: hw/rtl/atce_pkg.sv
// Shared types, codes and constants of the ANSI text console engine.
`default_nettype none
package atce_pkg;

  localparam int MAX_COLS    = 256;
  localparam int MAX_ROWS    = 128;
  localparam int NUM_SLOTS   = 8;
  localparam int QUEUE_DEPTH = 4;

  typedef logic [7:0] row_t;
  typedef logic [8:0] col_t;

  localparam logic [1:0] KIND_GLYPH  = 2'd0;
  localparam logic [1:0] KIND_FILL   = 2'd1;
  localparam logic [1:0] KIND_SCROLL = 2'd2;

  localparam logic [1:0] CFG_COLS = 2'd0;
  localparam logic [1:0] CFG_ROWS = 2'd1;

  localparam logic [7:0] CH_NUL      = 8'h00;
  localparam logic [7:0] CH_BS       = 8'h08;
  localparam logic [7:0] CH_TAB      = 8'h09;
  localparam logic [7:0] CH_LF       = 8'h0A;
  localparam logic [7:0] CH_ESC      = 8'h1B;
  localparam logic [7:0] CH_SPACE    = 8'h20;
  localparam logic [7:0] CH_ZERO     = 8'h30;
  localparam logic [7:0] CH_NINE     = 8'h39;
  localparam logic [7:0] CH_SEMI     = 8'h3B;
  localparam logic [7:0] CH_H        = 8'h48;
  localparam logic [7:0] CH_J        = 8'h4A;
  localparam logic [7:0] CH_K        = 8'h4B;
  localparam logic [7:0] CH_LBRACKET = 8'h5B;
  localparam logic [7:0] CH_M        = 8'h6D;

  localparam logic [13:0] PARAM_CAP = 14'd9999;
  localparam logic [3:0]  FG_DEFAULT = 4'd8;
  localparam logic [3:0]  BG_DEFAULT = 4'd9;

  // Order in which the commands of one byte are delivered.
  localparam int SLOT_A_S1 = 0;
  localparam int SLOT_A_S2 = 1;
  localparam int SLOT_A_G  = 2;
  localparam int SLOT_B_S1 = 3;
  localparam int SLOT_B_S2 = 4;
  localparam int SLOT_B_G  = 5;
  localparam int SLOT_B_S3 = 6;
  localparam int SLOT_FILL = 7;

  typedef struct packed {
    logic s1;
    logic s2;
    logic glyph;
    logic s3;
    row_t g_row;
    col_t g_col;
    row_t row;
    col_t col;
  } atce_prt_t;

  typedef struct packed {
    logic [NUM_SLOTS-1:0] slots;
    row_t                 a_row;
    col_t                 a_col;
    row_t                 b_row;
    col_t                 b_col;
    logic [7:0]           b_code;
    row_t                 f_srow;
    col_t                 f_scol;
    row_t                 f_erow;
    col_t                 f_ecol;
    logic [3:0]           fg;
    logic [3:0]           bg;
    logic                 bold;
  } atce_job_t;

  typedef struct packed {
    logic [1:0] kind;
    row_t       start_row;
    col_t       start_col;
    row_t       end_row;
    col_t       end_col;
    logic [7:0] glyph;
    logic [3:0] fg;
    logic [3:0] bg;
    logic       bold;
    logic       last;
  } atce_cmd_t;

endpackage
`default_nettype wire

FILE: hw/rtl/atce_print.sv
// Cursor movement and scroll decisions for printing one character.
`default_nettype none
module atce_print import atce_pkg::*; #(
  parameter int TAB_WIDTH = 8
) (
  input  wire logic       en,
  input  wire logic [7:0] code,
  input  wire row_t       row,
  input  wire col_t       col,
  input  wire col_t       cols,
  input  wire row_t       rows,
  output atce_prt_t       res
);

  localparam int         RECIP = 65536 / TAB_WIDTH;
  localparam logic [9:0] TW    = 10'(TAB_WIDTH);

  logic [24:0] prod;
  logic [8:0]  q;
  logic [9:0]  qtw;
  logic [9:0]  rem;
  logic [9:0]  tab_col;

  always_comb begin
    prod = 25'(col) * 25'(RECIP);
    q    = prod[24:16];
    qtw  = 10'(q) * TW;
    rem  = {1'b0, col} - qtw;
    if (rem >= TW) begin
      qtw = qtw + TW;
    end
    tab_col = qtw + TW;
  end

  always_comb begin
    logic [9:0] tc;
    row_t       r;
    col_t       c;
    tc  = tab_col;
    r   = row;
    c   = col;
    res = '0;
    if (en && code != CH_NUL) begin
      res.s1 = (row == rows);
      if (res.s1) begin
        r = row - 8'd1;
      end
      case (code)
        CH_LF: begin
          c = '0;
          r = r + 8'd1;
        end
        CH_TAB: begin
          if (tc > {1'b0, cols}) begin
            tc = tc - {1'b0, cols};
            r  = r + 8'd1;
          end
          c = tc[8:0];
        end
        default: begin
          if (col >= cols) begin
            c = '0;
            r = r + 8'd1;
          end
          if (r >= rows) begin
            res.s2 = 1'b1;
            r      = r - 8'd1;
          end
          res.glyph = 1'b1;
          res.g_row = r;
          res.g_col = c;
          c = c + 9'd1;
        end
      endcase
      if (!res.glyph && r >= rows && !(r == rows && c == '0)) begin
        res.s3 = 1'b1;
        r      = r - 8'd1;
      end
    end
    res.row = r;
    res.col = c;
  end

endmodule
`default_nettype wire

FILE: hw/rtl/atce_front.sv
// Front end: escape parser, cursor and attribute state, job classification.
`default_nettype none
module atce_front import atce_pkg::*; #(
  parameter int MAX_PARAMS = 16,
  parameter int TAB_WIDTH  = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       take,
  input  wire logic [7:0] in_byte,
  input  wire logic       cfg_we,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  output atce_job_t       job,
  output logic            job_valid
);

  localparam int CW = $clog2(MAX_PARAMS + 1);

  typedef enum logic [2:0] {
    PH_IDLE  = 3'b001,
    PH_CMD   = 3'b010,
    PH_PARAM = 3'b100
  } phase_t;

  phase_t      phase_r, phase_nxt;
  logic [1:0]  skip_r, skip_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [13:0] p0_r, p0_nxt, plast_r, plast_nxt;
  row_t        row_r, row_nxt, rows_r, rows_nxt;
  col_t        col_r, col_nxt, cols_r, cols_nxt;
  logic [3:0]  fg_r, fg_nxt, bg_r, bg_nxt;
  logic        bold_r, bold_nxt;

  logic        a_en, b_en, bs, home, fill_en;
  logic [7:0]  b_code;
  atce_prt_t   pr_a, pr_b;
  row_t        f_srow, f_erow, at_row;
  col_t        f_scol, f_ecol, at_col, cc;
  logic [1:0]  lead;
  logic [16:0] acc;
  logic [13:0] acc_sat;
  logic [13:0] sgr_fg, sgr_bg;

  atce_print #(.TAB_WIDTH(TAB_WIDTH)) u_prt_a (
    .en(a_en), .code(CH_ESC), .row(row_r), .col(col_r),
    .cols(cols_r), .rows(rows_r), .res(pr_a)
  );

  atce_print #(.TAB_WIDTH(TAB_WIDTH)) u_prt_b (
    .en(b_en), .code(b_code), .row(pr_a.row), .col(pr_a.col),
    .cols(cols_r), .rows(rows_r), .res(pr_b)
  );

  always_comb begin
    if ((in_byte & 8'hF8) == 8'hF0) begin
      lead = 2'd3;
    end else if ((in_byte & 8'hF0) == 8'hE0) begin
      lead = 2'd2;
    end else if ((in_byte & 8'hE0) == 8'hC0) begin
      lead = 2'd1;
    end else begin
      lead = 2'd0;
    end
    acc     = {3'b0, plast_r} * 17'd10 + 17'(in_byte - CH_ZERO);
    acc_sat = (acc > 17'(PARAM_CAP)) ? PARAM_CAP : acc[13:0];
    cc      = (col_r > cols_r) ? cols_r : col_r;
    at_row  = (cc == cols_r) ? row_r + 8'd1 : row_r;
    at_col  = (cc == cols_r) ? '0 : cc;
    sgr_fg  = plast_r - 14'd30;
    sgr_bg  = plast_r - 14'd40;
    b_code  = (in_byte == CH_BS) ? CH_SPACE : in_byte;
  end

  always_comb begin
    phase_nxt = phase_r;
    skip_nxt  = skip_r;
    cnt_nxt   = cnt_r;
    p0_nxt    = p0_r;
    plast_nxt = plast_r;
    fg_nxt    = fg_r;
    bg_nxt    = bg_r;
    bold_nxt  = bold_r;
    a_en      = 1'b0;
    b_en      = 1'b0;
    home      = 1'b0;
    fill_en   = 1'b0;
    f_srow    = '0;
    f_scol    = '0;
    f_erow    = '0;
    f_ecol    = '0;
    if (phase_r == PH_IDLE && skip_r == 2'd0 && in_byte[7]) begin
      skip_nxt = lead;
    end else if (skip_r != 2'd0) begin
      skip_nxt = skip_r - 2'd1;
    end else if (phase_r == PH_CMD && in_byte != CH_LBRACKET) begin
      a_en      = 1'b1;
      phase_nxt = PH_IDLE;
      cnt_nxt   = '0;
      if (in_byte[7]) begin
        skip_nxt = lead;
      end else if (in_byte == CH_ESC) begin
        phase_nxt = PH_CMD;
      end else begin
        b_en = 1'b1;
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          cnt_nxt = '0;
          if (in_byte == CH_ESC) begin
            phase_nxt = PH_CMD;
          end else begin
            b_en = 1'b1;
          end
        end
        PH_CMD: begin
          phase_nxt = PH_PARAM;
          cnt_nxt   = CW'(1);
          p0_nxt    = '0;
          plast_nxt = '0;
        end
        PH_PARAM: begin
          phase_nxt = PH_IDLE;
          cnt_nxt   = '0;
          if (in_byte == CH_SEMI) begin
            phase_nxt = PH_PARAM;
            cnt_nxt   = cnt_r;
            if (cnt_r < CW'(MAX_PARAMS)) begin
              cnt_nxt   = cnt_r + CW'(1);
              plast_nxt = '0;
            end
          end else if (in_byte >= CH_ZERO && in_byte <= CH_NINE) begin
            phase_nxt = PH_PARAM;
            cnt_nxt   = cnt_r;
            plast_nxt = acc_sat;
            if (cnt_r == CW'(1)) begin
              p0_nxt = acc_sat;
            end
          end else if (in_byte == CH_H) begin
            home = 1'b1;
          end else if (in_byte == CH_K) begin
            if (cnt_r == CW'(1) && p0_r <= 14'd2 && row_r < rows_r) begin
              f_srow = row_r;
              f_erow = row_r + 8'd1;
              if (p0_r == 14'd0) begin
                fill_en = (cc != cols_r);
                f_scol  = cc;
              end else if (p0_r == 14'd1) begin
                fill_en = (cc != '0);
                f_erow  = at_row;
                f_ecol  = at_col;
              end else begin
                fill_en = 1'b1;
              end
            end
          end else if (in_byte == CH_J) begin
            if (cnt_r == CW'(1)) begin
              if (p0_r == 14'd0) begin
                fill_en = !(at_row == rows_r && at_col == '0);
                f_srow  = at_row;
                f_scol  = at_col;
                f_erow  = rows_r;
              end else if (p0_r == 14'd1) begin
                fill_en = !(at_row == '0 && at_col == '0);
                f_erow  = at_row;
                f_ecol  = at_col;
              end else if (p0_r == 14'd2) begin
                fill_en = 1'b1;
                f_erow  = rows_r;
              end
            end else begin
              b_en = 1'b1;
            end
          end else if (in_byte == CH_M) begin
            bold_nxt = (cnt_r > CW'(1)) && (p0_r != 14'd0);
            if (plast_r == 14'd0) begin
              fg_nxt = FG_DEFAULT;
              bg_nxt = BG_DEFAULT;
            end else if (plast_r >= 14'd30 && plast_r <= 14'd37) begin
              fg_nxt = sgr_fg[3:0];
              bg_nxt = BG_DEFAULT;
            end else if (plast_r >= 14'd40 && plast_r <= 14'd47) begin
              bg_nxt = sgr_bg[3:0];
            end
          end else begin
            b_en = 1'b1;
          end
        end
        default: begin
          phase_nxt = PH_IDLE;
        end
      endcase
    end
    bs = b_en && (in_byte == CH_BS);
  end

  always_comb begin
    col_t nc;
    row_t nr;
    nc       = (cfg_index == CFG_COLS) ?
               ((cfg_data == 9'd0) ? 9'd1 :
                (cfg_data > 9'(MAX_COLS)) ? 9'(MAX_COLS) : cfg_data) : cols_r;
    nr       = (cfg_index == CFG_ROWS) ?
               ((cfg_data[7:0] == 8'd0) ? 8'd1 :
                (cfg_data[7:0] > 8'(MAX_ROWS)) ? 8'(MAX_ROWS) : cfg_data[7:0]) : rows_r;
    cols_nxt = cols_r;
    rows_nxt = rows_r;
    if (home) begin
      row_nxt = '0;
      col_nxt = '0;
    end else if (bs) begin
      row_nxt = pr_b.row;
      col_nxt = (pr_b.col >= 9'd2) ? pr_b.col - 9'd2 : '0;
    end else begin
      row_nxt = pr_b.row;
      col_nxt = pr_b.col;
    end
    if (cfg_we) begin
      row_nxt = row_r;
      col_nxt = col_r;
      if (cfg_index == CFG_COLS || cfg_index == CFG_ROWS) begin
        cols_nxt = nc;
        rows_nxt = nr;
        if (row_r > nr || (row_r == nr && col_r != '0)) begin
          row_nxt = nr;
          col_nxt = '0;
        end else if (col_r > nc) begin
          col_nxt = nc;
        end
      end
    end
  end

  always_comb begin
    job                  = '0;
    job.slots[SLOT_A_S1] = pr_a.s1;
    job.slots[SLOT_A_S2] = pr_a.s2;
    job.slots[SLOT_A_G]  = pr_a.glyph;
    job.slots[SLOT_B_S1] = pr_b.s1;
    job.slots[SLOT_B_S2] = pr_b.s2;
    job.slots[SLOT_B_G]  = pr_b.glyph;
    job.slots[SLOT_B_S3] = pr_b.s3;
    job.slots[SLOT_FILL] = fill_en;
    job.a_row            = pr_a.g_row;
    job.a_col            = pr_a.g_col;
    job.b_row            = pr_b.g_row;
    job.b_col            = pr_b.g_col;
    job.b_code           = b_code;
    job.f_srow           = f_srow;
    job.f_scol           = f_scol;
    job.f_erow           = f_erow;
    job.f_ecol           = f_ecol;
    job.fg               = fg_r;
    job.bg               = bg_r;
    job.bold             = bold_r;
    job_valid            = |job.slots;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      skip_r  <= '0;
      cnt_r   <= '0;
      p0_r    <= '0;
      plast_r <= '0;
      row_r   <= '0;
      col_r   <= '0;
      fg_r    <= FG_DEFAULT;
      bg_r    <= BG_DEFAULT;
      bold_r  <= 1'b0;
      cols_r  <= 9'd80;
      rows_r  <= 8'd25;
    end else if (cfg_we) begin
      cols_r <= cols_nxt;
      rows_r <= rows_nxt;
      row_r  <= row_nxt;
      col_r  <= col_nxt;
    end else if (take) begin
      phase_r <= phase_nxt;
      skip_r  <= skip_nxt;
      cnt_r   <= cnt_nxt;
      p0_r    <= p0_nxt;
      plast_r <= plast_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
      fg_r    <= fg_nxt;
      bg_r    <= bg_nxt;
      bold_r  <= bold_nxt;
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/atce_fifo.sv
// Short job queue between the front end and the back end.
`default_nettype none
module atce_fifo import atce_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire logic      push,
  input  wire atce_job_t push_job,
  input  wire logic      pop,
  output atce_job_t      head,
  output logic           full,
  output logic           empty
);

  localparam int PW = $clog2(QUEUE_DEPTH);

  atce_job_t     mem_r [QUEUE_DEPTH];
  logic [PW-1:0] wp_r, rp_r;
  logic [PW:0]   cnt_r;

  assign full  = (cnt_r == (PW + 1)'(QUEUE_DEPTH));
  assign empty = (cnt_r == '0);
  assign head  = mem_r[rp_r];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      mem_r[wp_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push && !full) begin
        wp_r <= (wp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : wp_r + PW'(1);
      end
      if (pop && !empty) begin
        rp_r <= (rp_r == PW'(QUEUE_DEPTH - 1)) ? '0 : rp_r + PW'(1);
      end
      cnt_r <= cnt_r + (PW + 1)'(push && !full) - (PW + 1)'(pop && !empty);
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/atce_back.sv
// Back end: expands jobs into commands, one per cycle unless stalled.
`default_nettype none
module atce_back import atce_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst_n,
  input  wire atce_job_t head,
  input  wire logic      head_valid,
  output logic           head_pop,
  input  wire logic      out_pop,
  output logic           out_valid,
  output atce_cmd_t      out_cmd
);

  logic [NUM_SLOTS-1:0] served_r, served_nxt, remaining, pick_oh;
  logic                 out_valid_r, load, last;
  atce_cmd_t            cmd_r, cmd_nxt;

  assign out_valid = out_valid_r;
  assign out_cmd   = cmd_r;
  assign remaining = head.slots & ~served_r;
  assign load      = head_valid && (!out_valid_r || out_pop);

  always_comb begin
    pick_oh = '0;
    for (int i = NUM_SLOTS - 1; i >= 0; i--) begin
      if (remaining[i]) begin
        pick_oh = '0;
        pick_oh[i] = 1'b1;
      end
    end
    last       = ((remaining & ~pick_oh) == '0);
    head_pop   = load && last;
    served_nxt = last ? '0 : (served_r | pick_oh);

    cmd_nxt      = '0;
    cmd_nxt.kind = KIND_SCROLL;
    cmd_nxt.bg   = head.bg;
    cmd_nxt.last = last;
    if (pick_oh[SLOT_A_G]) begin
      cmd_nxt.kind      = KIND_GLYPH;
      cmd_nxt.start_row = head.a_row;
      cmd_nxt.start_col = head.a_col;
      cmd_nxt.glyph     = CH_ESC;
      cmd_nxt.fg        = head.fg;
      cmd_nxt.bold      = head.bold;
    end else if (pick_oh[SLOT_B_G]) begin
      cmd_nxt.kind      = KIND_GLYPH;
      cmd_nxt.start_row = head.b_row;
      cmd_nxt.start_col = head.b_col;
      cmd_nxt.glyph     = head.b_code;
      cmd_nxt.fg        = head.fg;
      cmd_nxt.bold      = head.bold;
    end else if (pick_oh[SLOT_FILL]) begin
      cmd_nxt.kind      = KIND_FILL;
      cmd_nxt.start_row = head.f_srow;
      cmd_nxt.start_col = head.f_scol;
      cmd_nxt.end_row   = head.f_erow;
      cmd_nxt.end_col   = head.f_ecol;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      cmd_r <= cmd_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      served_r    <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        served_r    <= served_nxt;
      end else if (out_pop) begin
        out_valid_r <= 1'b0;
      end
    end
  end

endmodule
`default_nettype wire

FILE: hw/rtl/ansi_text_console_engine_core.sv
// Top level of the ANSI text console engine.
//
// The input side is a queue: a byte is taken at a clock edge with in_push high
// and in_full low. The front end parses it and updates the cursor, colours and
// escape state in that same cycle, then places the commands the byte causes
// into a four-entry job queue as one item. Bytes causing no command leave no
// job. The back end delivers one command per cycle, while out_pop keeps up,
// into an output register: out_empty low shows a command, and out_pop takes
// it. last_of_run marks the final command of one byte.
// A byte can be taken every cycle while in_full is low; its first command
// goes through the job queue and the output register. A byte causes up to
// five commands; the back end sustains one command per cycle, so bytes with
// several commands fill the job queue and raise in_full until it drains.
// When the receiver holds off out_pop, the output register keeps its command,
// the job queue fills and in_full rises; nothing is lost.
// Configuration writes are taken at once (cfg_ready is always high), hold off
// input items by raising in_full in that cycle, and pull the cursor inside the
// new screen. Reset empties the queue and output, homes the cursor, sets
// default colours and an 80 by 25 screen.
`default_nettype none
module ansi_text_console_engine_core import atce_pkg::*; #(
  parameter int MAX_PARAMS = 16,
  parameter int TAB_WIDTH  = 8
) (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  output logic            in_full,
  input  wire logic [7:0] in_byte,
  output logic            out_empty,
  input  wire logic       out_pop,
  output logic [1:0]      out_command_kind,
  output logic [7:0]      out_start_row,
  output logic [8:0]      out_start_col,
  output logic [7:0]      out_end_row,
  output logic [8:0]      out_end_col,
  output logic [7:0]      out_glyph_code,
  output logic [3:0]      out_fore_color,
  output logic [3:0]      out_back_color,
  output logic            out_bold_on,
  output logic            out_last_of_run,
  input  wire logic       cfg_valid,
  output logic            cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data
);

  atce_job_t job, head;
  atce_cmd_t cmd;
  logic      job_valid, take, q_full, q_empty, head_pop, out_valid;

  assign cfg_ready = 1'b1;
  assign in_full   = q_full || cfg_valid;
  assign take      = in_push && !in_full;

  atce_front #(.MAX_PARAMS(MAX_PARAMS), .TAB_WIDTH(TAB_WIDTH)) u_front (
    .clk(clk), .rst_n(rst_n), .take(take), .in_byte(in_byte),
    .cfg_we(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .job(job), .job_valid(job_valid)
  );

  atce_fifo u_fifo (
    .clk(clk), .rst_n(rst_n), .push(take && job_valid), .push_job(job),
    .pop(head_pop), .head(head), .full(q_full), .empty(q_empty)
  );

  atce_back u_back (
    .clk(clk), .rst_n(rst_n), .head(head), .head_valid(!q_empty),
    .head_pop(head_pop), .out_pop(out_pop), .out_valid(out_valid), .out_cmd(cmd)
  );

  assign out_empty        = !out_valid;
  assign out_command_kind = cmd.kind;
  assign out_start_row    = cmd.start_row;
  assign out_start_col    = cmd.start_col;
  assign out_end_row      = cmd.end_row;
  assign out_end_col      = cmd.end_col;
  assign out_glyph_code   = cmd.glyph;
  assign out_fore_color   = cmd.fg;
  assign out_back_color   = cmd.bg;
  assign out_bold_on      = cmd.bold;
  assign out_last_of_run  = cmd.last;

endmodule
`default_nettype wire

FILE: hw/rtl/atce_checker.sv
// Port-level checks of the console engine and their binding to the top level.
`default_nettype none
module atce_props import atce_pkg::*; (
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       out_empty,
  input wire logic       out_pop,
  input wire logic [1:0] out_command_kind,
  input wire logic [7:0] out_start_row,
  input wire logic [8:0] out_start_col,
  input wire logic [7:0] out_end_row,
  input wire logic [8:0] out_end_col,
  input wire logic [7:0] out_glyph_code,
  input wire logic       out_last_of_run
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> out_empty)
    else $error("result present after reset");

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && !out_pop) |=> (!out_empty && $stable(out_command_kind) &&
      $stable(out_glyph_code) && $stable(out_last_of_run)))
    else $error("waiting result changed");

  a_kind: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_command_kind == KIND_GLYPH || out_command_kind == KIND_FILL ||
      out_command_kind == KIND_SCROLL))
    else $error("bad command kind");

  a_scroll_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_command_kind == KIND_SCROLL) |->
      (out_start_row == '0 && out_start_col == '0 && out_end_row == '0 &&
       out_end_col == '0 && out_glyph_code == '0))
    else $error("scroll command carries coordinates");

  a_glyph_end_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_command_kind == KIND_GLYPH) |->
      (out_end_row == '0 && out_end_col == '0))
    else $error("glyph command carries an end cell");

endmodule

bind ansi_text_console_engine_core atce_props u_atce_props (
  .clk(clk), .rst_n(rst_n),
  .out_empty(out_empty), .out_pop(out_pop), .out_command_kind(out_command_kind),
  .out_start_row(out_start_row), .out_start_col(out_start_col),
  .out_end_row(out_end_row), .out_end_col(out_end_col),
  .out_glyph_code(out_glyph_code), .out_last_of_run(out_last_of_run)
);
`default_nettype wire

FILE: tb/sv/atce_checker.sv
// Checker for the console engine: predicts the drawing commands of each byte and compares them.
module atce_checker import atce_pkg::*; (
  input  wire logic       clk,
  input  wire logic       rst_n,
  input  wire logic       in_push,
  input  wire logic       in_full,
  input  wire logic [7:0] in_byte,
  input  wire logic       out_empty,
  input  wire logic       out_pop,
  input  wire logic [1:0] out_command_kind,
  input  wire logic [7:0] out_start_row,
  input  wire logic [8:0] out_start_col,
  input  wire logic [7:0] out_end_row,
  input  wire logic [8:0] out_end_col,
  input  wire logic [7:0] out_glyph_code,
  input  wire logic [3:0] out_fore_color,
  input  wire logic [3:0] out_back_color,
  input  wire logic       out_bold_on,
  input  wire logic       out_last_of_run,
  input  wire logic       cfg_valid,
  input  wire logic       cfg_ready,
  input  wire logic [1:0] cfg_index,
  input  wire logic [8:0] cfg_data,
  output int              errors,
  output int              outstanding,
  output int              checked
);

  localparam int TABW    = 8;
  localparam int NPARAMS = 16;

  typedef enum logic [1:0] {PH_IDLE, PH_CMD, PH_PARAM} phase_e;

  atce_cmd_t   cmd_q[$];
  int          run_len;
  logic [8:0]  columns;
  logic [7:0]  rows;
  phase_e      phase;
  logic        esc_pend;
  logic [13:0] params[NPARAMS];
  logic [4:0]  pcount;
  col_t        ccol;
  row_t        crow;
  logic [3:0]  fg;
  logic [3:0]  bg;
  logic        bold;
  logic [1:0]  skip;

  assign outstanding = cmd_q.size();

  function automatic int unsigned cols_used();
    return (columns < 1) ? 1 : (columns > MAX_COLS) ? MAX_COLS : columns;
  endfunction

  function automatic int unsigned rows_used();
    return (rows < 1) ? 1 : (rows > MAX_ROWS) ? MAX_ROWS : rows;
  endfunction

  function automatic void push_cmd(logic [1:0] kind, int unsigned sr, int unsigned sc,
                                   int unsigned er, int unsigned ec, logic [7:0] code,
                                   logic [3:0] f, logic [3:0] b, logic bo);
    atce_cmd_t c;
    if (run_len >= NUM_SLOTS) return;
    c.kind = kind;
    c.start_row = row_t'(sr);
    c.start_col = col_t'(sc);
    c.end_row = row_t'(er);
    c.end_col = col_t'(ec);
    c.glyph = code;
    c.fg = f;
    c.bg = b;
    c.bold = bo;
    c.last = 1'b0;
    cmd_q.push_back(c);
    run_len++;
  endfunction

  function automatic void scroll_up();
    push_cmd(KIND_SCROLL, 0, 0, 0, 0, 8'd0, 4'd0, bg, 1'b0);
    crow = crow - 8'd1;
  endfunction

  function automatic void fill_range(int unsigned lo, int unsigned hi);
    int unsigned c;
    c = cols_used();
    if (hi <= lo) return;
    push_cmd(KIND_FILL, lo / c, lo % c, hi / c, hi % c, 8'd0, 4'd0, bg, 1'b0);
  endfunction

  function automatic void put_char(logic [7:0] ch);
    int unsigned nr;
    int unsigned nc;
    nr = rows_used();
    nc = cols_used();
    if (ch != CH_NUL && crow == nr) scroll_up();
    if (ch == CH_NUL) return;
    if (ch == CH_LF) begin
      ccol = 9'd0;
      crow = crow + 8'd1;
    end else if (ch == CH_TAB) begin
      ccol = col_t'(ccol + (TABW - ccol % TABW));
      if (ccol > nc) begin
        ccol = col_t'(ccol - nc);
        crow = crow + 8'd1;
      end
    end else begin
      if (ccol >= nc) begin
        ccol = 9'd0;
        crow = crow + 8'd1;
      end
      if (crow >= nr) scroll_up();
      push_cmd(KIND_GLYPH, crow, ccol, 0, 0, ch, fg, bg, bold);
      ccol = ccol + 9'd1;
    end
    while (crow >= nr && !(crow == nr && ccol == 0)) scroll_up();
  endfunction

  function automatic void draw_byte(logic [7:0] ch);
    if (ch == CH_BS) begin
      put_char(CH_SPACE);
      if (ccol > 0) ccol = ccol - 9'd1;
      if (ccol > 0) ccol = ccol - 9'd1;
    end else begin
      put_char(ch);
    end
  endfunction

  function automatic void erase_in_line();
    int unsigned nc;
    int unsigned col;
    int unsigned base;
    nc = cols_used();
    col = (ccol > nc) ? nc : ccol;
    if (pcount != 1 || params[0] > 2) return;
    if (crow >= rows_used()) return;
    base = crow * nc;
    if (params[0] == 0) fill_range(base + col, base + nc);
    else if (params[0] == 1) fill_range(base, base + col);
    else fill_range(base, base + nc);
  endfunction

  function automatic void erase_in_display();
    int unsigned nc;
    int unsigned total;
    int unsigned col;
    int unsigned at;
    nc = cols_used();
    total = rows_used() * nc;
    col = (ccol > nc) ? nc : ccol;
    at = crow * nc + col;
    if (at > total) at = total;
    if (params[0] == 0) fill_range(at, total);
    else if (params[0] == 1) fill_range(0, at);
    else if (params[0] == 2) fill_range(0, total);
  endfunction

  function automatic void set_rendition();
    int unsigned lastp;
    lastp = params[(pcount == 0) ? 0 : (pcount - 1) % NPARAMS];
    bold = (pcount > 1 && params[0] != 0);
    if (lastp == 0) begin
      fg = FG_DEFAULT;
      bg = BG_DEFAULT;
    end else if (lastp >= 30 && lastp <= 37) begin
      fg = 4'(lastp - 30);
      bg = BG_DEFAULT;
    end else if (lastp >= 40 && lastp <= 47) begin
      bg = 4'(lastp - 40);
    end
  endfunction

  // Returns 1 when the escape parser swallows the byte.
  function automatic bit parse_csi(logic [7:0] ch);
    bit ok;
    int unsigned idx;
    int unsigned v;
    ok = 0;
    if (phase == PH_IDLE) begin
      if (ch == CH_ESC && !esc_pend) begin
        phase = PH_CMD;
        esc_pend = 1;
        return 1;
      end
      esc_pend = 0;
    end else if (phase == PH_CMD) begin
      if (ch == CH_LBRACKET) begin
        pcount = 5'd1;
        params[0] = 14'd0;
        phase = PH_PARAM;
        return 1;
      end
    end else begin
      idx = (pcount == 0) ? 0 : (pcount - 1) % NPARAMS;
      if (ch == CH_SEMI) begin
        if (pcount < NPARAMS) begin
          params[pcount] = 14'd0;
          pcount = pcount + 5'd1;
        end
        return 1;
      end else if (ch >= CH_ZERO && ch <= CH_NINE) begin
        v = params[idx] * 10 + (ch - CH_ZERO);
        params[idx] = (v > PARAM_CAP) ? PARAM_CAP : 14'(v);
        return 1;
      end else if (ch == CH_H) begin
        ccol = 9'd0;
        crow = 8'd0;
        ok = 1;
      end else if (ch == CH_K) begin
        erase_in_line();
        ok = 1;
      end else if (ch == CH_J) begin
        if (pcount == 1) begin
          erase_in_display();
          ok = 1;
        end
      end else if (ch == CH_M) begin
        set_rendition();
        ok = 1;
      end
    end
    phase = PH_IDLE;
    pcount = 5'd0;
    return ok;
  endfunction

  function automatic void console_step(logic [7:0] ch);
    run_len = 0;
    for (int pass = 0; pass < 2; pass++) begin
      if (ch[7] && skip == 0 && phase == PH_IDLE) begin
        if ((ch & 8'hF8) == 8'hF0) skip = 2'd3;
        else if ((ch & 8'hF0) == 8'hE0) skip = 2'd2;
        else if ((ch & 8'hE0) == 8'hC0) skip = 2'd1;
        else skip = 2'd0;
        break;
      end else if (skip != 0) begin
        skip = skip - 2'd1;
        break;
      end else if (esc_pend && ch != CH_LBRACKET) begin
        phase = PH_IDLE;
        pcount = 5'd0;
        draw_byte(CH_ESC);
        esc_pend = 0;
      end else begin
        esc_pend = 0;
        if (!parse_csi(ch)) draw_byte(ch);
        break;
      end
    end
    if (run_len > 0) cmd_q[cmd_q.size() - 1].last = 1'b1;
  endfunction

  function automatic void write_register(logic [1:0] idx, logic [8:0] data);
    int unsigned nr;
    int unsigned nc;
    if (idx == CFG_COLS) columns = data;
    else if (idx == CFG_ROWS) rows = data[7:0];
    else return;
    nr = rows_used();
    nc = cols_used();
    if (crow > nr || (crow == nr && ccol != 0)) begin
      crow = row_t'(nr);
      ccol = 9'd0;
    end else if (ccol > nc) begin
      ccol = col_t'(nc);
    end
  endfunction

  function automatic void check_field(string name, int unsigned expv, int unsigned actv);
    if (expv != actv) begin
      $error("%s: expected %0d, got %0d", name, expv, actv);
      errors++;
    end
  endfunction

  initial begin
    errors = 0;
    checked = 0;
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      cmd_q.delete();
      columns = 9'd80;
      rows = 8'd25;
      phase = PH_IDLE;
      esc_pend = 0;
      for (int i = 0; i < NPARAMS; i++) params[i] = 14'd0;
      pcount = 5'd0;
      ccol = 9'd0;
      crow = 8'd0;
      fg = FG_DEFAULT;
      bg = BG_DEFAULT;
      bold = 0;
      skip = 2'd0;
    end else begin
      if (out_pop && !out_empty) begin
        if (cmd_q.size() == 0) begin
          $error("command with no item waiting for it");
          errors++;
        end else begin
          atce_cmd_t e;
          e = cmd_q.pop_front();
          check_field("command_kind", e.kind, out_command_kind);
          check_field("start_row", e.start_row, out_start_row);
          check_field("start_col", e.start_col, out_start_col);
          check_field("end_row", e.end_row, out_end_row);
          check_field("end_col", e.end_col, out_end_col);
          check_field("glyph_code", e.glyph, out_glyph_code);
          check_field("fore_color", e.fg, out_fore_color);
          check_field("back_color", e.bg, out_back_color);
          check_field("bold_on", e.bold, out_bold_on);
          check_field("last_of_run", e.last, out_last_of_run);
          checked++;
        end
      end
      if (cfg_valid && cfg_ready) write_register(cfg_index, cfg_data);
      if (in_push && !in_full) console_step(in_byte);
    end
  end

endmodule

FILE: tb/sv/tb.sv
// Testbench top: drives bytes, register writes and output stalls into the console engine.
module tb;
  import atce_pkg::*;

  localparam int LIMIT = 400000;

  logic       clk = 0;
  logic       rst_n = 0;
  logic       in_push = 0;
  logic       in_full;
  logic [7:0] in_byte = 0;
  logic       out_empty;
  logic       out_pop = 0;
  logic [1:0] out_command_kind;
  logic [7:0] out_start_row;
  logic [8:0] out_start_col;
  logic [7:0] out_end_row;
  logic [8:0] out_end_col;
  logic [7:0] out_glyph_code;
  logic [3:0] out_fore_color;
  logic [3:0] out_back_color;
  logic       out_bold_on;
  logic       out_last_of_run;
  logic       cfg_valid = 0;
  logic       cfg_ready;
  logic [1:0] cfg_index = 0;
  logic [8:0] cfg_data = 0;

  int errors;
  int outstanding;
  int checked;
  int cycles = 0;
  int bytes_sent = 0;
  int idle_pct = 0;
  int stall_pct = 0;

  ansi_text_console_engine_core dut (.*);

  atce_checker chk (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_pop <= ($urandom_range(0, 99) >= stall_pct);
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic send(logic [7:0] b);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_push <= 0;
      @(posedge clk);
    end
    in_push <= 1;
    in_byte <= b;
    do @(posedge clk); while (in_full);
    bytes_sent++;
  endtask

  task automatic send_str(string s);
    for (int i = 0; i < s.len(); i++) send(s[i]);
  endtask

  task automatic drain();
    in_push <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (16) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [8:0] data);
    drain();
    cfg_valid <= 1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
  endtask

  task automatic send_csi();
    int n;
    int v;
    n = ($urandom_range(0, 19) == 0) ? $urandom_range(15, 19) : $urandom_range(0, 3);
    send(CH_ESC);
    send(CH_LBRACKET);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 5))
        0: v = $urandom_range(0, 2);
        1: v = $urandom_range(30, 37);
        2: v = $urandom_range(40, 47);
        3: v = $urandom_range(0, 99999);
        default: v = $urandom_range(0, 50);
      endcase
      if (i > 0) send(CH_SEMI);
      if ($urandom_range(0, 7) != 0) send_str($sformatf("%0d", v));
    end
    case ($urandom_range(0, 5))
      0: send(CH_H);
      1: send(CH_K);
      2: send(CH_J);
      3, 4: send(CH_M);
      default: send(8'($urandom_range(0, 255)));
    endcase
  endtask

  task automatic send_chunk();
    int n;
    case ($urandom_range(0, 9))
      0, 1, 2: begin
        n = $urandom_range(1, 6);
        repeat (n) send(8'($urandom_range(32, 126)));
      end
      3: begin
        case ($urandom_range(0, 4))
          0: send(CH_BS);
          1: send(CH_TAB);
          2: send(CH_LF);
          3: send(CH_NUL);
          default: send(CH_SPACE);
        endcase
      end
      4, 5, 6: send_csi();
      7: begin
        send(CH_ESC);
        send(8'($urandom_range(0, 255)));
      end
      8: begin
        case ($urandom_range(0, 3))
          0: begin send(8'hC0 | 8'($urandom_range(0, 31))); n = 1; end
          1: begin send(8'hE0 | 8'($urandom_range(0, 15))); n = 2; end
          2: begin send(8'hF0 | 8'($urandom_range(0, 7))); n = 3; end
          default: begin send($urandom_range(0, 1) ? 8'($urandom_range(8'h80, 8'hBF))
                                                   : 8'($urandom_range(8'hF8, 8'hFF))); n = 0; end
        endcase
        repeat (n) send(8'($urandom_range(8'h80, 8'hBF)));
      end
      default: send(8'($urandom_range(0, 255)));
    endcase
  endtask

  initial begin
    int cols_set[6] = '{80, 1, 256, 7, 12, 40};
    int rows_set[6] = '{25, 1, 128, 3, 5, 2};
    int idle_set[4] = '{0, 45, 0, 29};
    int stall_set[4] = '{0, 0, 45, 29};
    int target;
    repeat (9) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // Directed bytes at the reset screen.
    send_str("A~ ");
    send(CH_NUL);
    send(CH_BS);
    send(CH_TAB);
    send(CH_LF);
    send_str("\033[1;31mX\033[44mY\033[0m\033[99999;7m");
    send_str("\033[0K\033[1K\033[2K\033[3K\033[1;2K");
    send_str("\033[J\033[1J\033[2J\033[5J\033[1;2J\033[H");
    send_str("\033x\033\033[\033[5X");
    send_str("\033[;;;;;;;;;;;;;;;;;;42m");
    send(8'hC3); send(8'hA9);
    send(8'hE2); send(8'h82); send(8'hAC);
    send(8'hF0); send(8'h9F); send(8'h98); send(8'h80);
    send(8'h80); send(8'hFF);

    for (int p = 0; p < 6; p++) begin
      write_reg(CFG_COLS, 9'((p == 5) ? $urandom_range(1, 256) : cols_set[p]));
      write_reg(CFG_ROWS, 9'((p == 5) ? $urandom_range(1, 128) : rows_set[p]));
      idle_pct = idle_set[p % 4];
      stall_pct = stall_set[p % 4];
      target = bytes_sent + 52;
      while (bytes_sent < target) begin
        send_chunk();
        if (bytes_sent > target - 40 && bytes_sent < target - 33) drain();
      end
    end

    in_push <= 0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (20) @(posedge clk);
    $display("tb: %0d bytes sent, %0d commands checked over six screen sizes and four",
             bytes_sent, checked);
    $display("tb: idle and stall mixes, with escape, UTF-8 and control byte cases");
    if (errors == 0 && outstanding == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule
